// ----- sv/csd_pkg.sv -----
package csd_pkg;

    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int DIFF_W   = 32;

    // Day count since 2000-01-01 fits 16 bits for any 7-bit year.
    localparam int DCOUNT_W = 16;
    // Seconds of day fit 17 bits even for out-of-range hour and minute codes.
    localparam int TOD_W    = 17;
    localparam int DDIFF_W  = DCOUNT_W + 1;
    localparam int TDIFF_W  = TOD_W + 1;
    localparam int SCALE_W  = 18;
    localparam int PROD_W   = DDIFF_W + SCALE_W;
    localparam int SUM_W    = PROD_W + 1;

    localparam int NUM_STAGES = 4;

    localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
    localparam logic [16:0] SECONDS_PER_DAY    = 17'd86400;
    localparam logic [11:0] SECONDS_PER_HOUR   = 12'd3600;
    localparam logic [5:0]  SECONDS_PER_MINUTE = 6'd60;
    localparam logic [3:0]  LAST_MONTH         = 4'd12;

    localparam logic [8:0] CUM_COMMON [0:11] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam logic [8:0] CUM_LEAP [0:11] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    typedef struct packed {
        logic signed [DDIFF_W-1:0] day_diff;
        logic signed [TDIFF_W-1:0] tod_diff;
        logic                      earlier;
    } csd_delta_t;

    // Days from 2000-01-01; month codes outside 1..12 clamp to January or December.
    function automatic logic [DCOUNT_W-1:0] day_count(
        input logic [YEAR_W-1:0]  year,
        input logic [MONTH_W-1:0] month,
        input logic [DAY_W-1:0]   day
    );
        logic [3:0]          idx;
        logic [8:0]          prior_days;
        logic [YEAR_W:0]     leap_sum;
        logic [DCOUNT_W-1:0] year_days;
        if (month == '0)
            idx = 4'd0;
        else if (month > LAST_MONTH)
            idx = 4'd11;
        else
            idx = month - 4'd1;
        prior_days = (year[1:0] == 2'b00) ? CUM_LEAP[idx] : CUM_COMMON[idx];
        leap_sum   = {1'b0, year} + 8'd3;
        year_days  = DCOUNT_W'({9'd0, year} * {7'd0, DAYS_PER_YEAR});
        return year_days + DCOUNT_W'(leap_sum >> 2) + DCOUNT_W'(prior_days)
             + DCOUNT_W'(day);
    endfunction

    function automatic logic [TOD_W-1:0] time_of_day(
        input logic [HOUR_W-1:0]   hour,
        input logic [MINUTE_W-1:0] minute,
        input logic [SECOND_W-1:0] second
    );
        logic [TOD_W-1:0] h_part;
        logic [TOD_W-1:0] m_part;
        h_part = TOD_W'({12'd0, hour} * {5'd0, SECONDS_PER_HOUR});
        m_part = TOD_W'({6'd0, minute} * {6'd0, SECONDS_PER_MINUTE});
        return h_part + m_part + TOD_W'(second);
    endfunction

endpackage

// ----- sv/csd_front.sv -----
module csd_front (
    input  logic                           clk,
    input  logic                           en,
    input  logic [csd_pkg::YEAR_W-1:0]     from_year,
    input  logic [csd_pkg::MONTH_W-1:0]    from_month,
    input  logic [csd_pkg::DAY_W-1:0]      from_day,
    input  logic [csd_pkg::HOUR_W-1:0]     from_hour,
    input  logic [csd_pkg::MINUTE_W-1:0]   from_minute,
    input  logic [csd_pkg::SECOND_W-1:0]   from_second,
    input  logic [csd_pkg::YEAR_W-1:0]     to_year,
    input  logic [csd_pkg::MONTH_W-1:0]    to_month,
    input  logic [csd_pkg::DAY_W-1:0]      to_day,
    input  logic [csd_pkg::HOUR_W-1:0]     to_hour,
    input  logic [csd_pkg::MINUTE_W-1:0]   to_minute,
    input  logic [csd_pkg::SECOND_W-1:0]   to_second,
    output csd_pkg::csd_delta_t            delta
);

    // Stage 1: day counts, seconds of day and the order test.
    logic [csd_pkg::DCOUNT_W-1:0] dc_from_reg, dc_from_next;
    logic [csd_pkg::DCOUNT_W-1:0] dc_to_reg, dc_to_next;
    logic [csd_pkg::TOD_W-1:0]    tod_from_reg, tod_from_next;
    logic [csd_pkg::TOD_W-1:0]    tod_to_reg, tod_to_next;
    logic                         earlier_reg, earlier_next;
    // Stage 2: differences.
    csd_pkg::csd_delta_t          delta_reg, delta_next;

    always_comb
    begin
        dc_from_next  = csd_pkg::day_count(from_year, from_month, from_day);
        dc_to_next    = csd_pkg::day_count(to_year, to_month, to_day);
        tod_from_next = csd_pkg::time_of_day(from_hour, from_minute, from_second);
        tod_to_next   = csd_pkg::time_of_day(to_hour, to_minute, to_second);
        // With fixed field widths a lexicographic compare is a compare of the concatenation.
        earlier_next  = {from_year, from_month, from_day, from_hour, from_minute, from_second}
                      < {to_year, to_month, to_day, to_hour, to_minute, to_second};
    end

    always_comb
    begin
        delta_next.day_diff = $signed({1'b0, dc_to_reg}) - $signed({1'b0, dc_from_reg});
        delta_next.tod_diff = $signed({1'b0, tod_to_reg}) - $signed({1'b0, tod_from_reg});
        delta_next.earlier  = earlier_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dc_from_reg  <= dc_from_next;
            dc_to_reg    <= dc_to_next;
            tod_from_reg <= tod_from_next;
            tod_to_reg   <= tod_to_next;
            earlier_reg  <= earlier_next;
            delta_reg    <= delta_next;
        end
    end

    assign delta = delta_reg;

endmodule

// ----- sv/csd_scale.sv -----
module csd_scale (
    input  logic                          clk,
    input  logic                          en,
    input  csd_pkg::csd_delta_t           delta,
    output logic [csd_pkg::DIFF_W-1:0]    diff_seconds
);

    // Stage 3: day difference scaled to seconds.
    logic signed [csd_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic signed [csd_pkg::TDIFF_W-1:0] tod_diff_reg;
    logic                               earlier_reg;
    // Stage 4: sum and clamp.
    logic [csd_pkg::DIFF_W-1:0]         diff_reg, diff_next;
    logic signed [csd_pkg::SUM_W-1:0]   sum;

    localparam logic signed [csd_pkg::SCALE_W-1:0] DAY_SCALE =
        $signed({1'b0, csd_pkg::SECONDS_PER_DAY});
    localparam logic signed [csd_pkg::SUM_W-1:0] DIFF_MAX =
        $signed({{(csd_pkg::SUM_W-csd_pkg::DIFF_W){1'b0}}, {csd_pkg::DIFF_W{1'b1}}});

    assign prod_next = csd_pkg::PROD_W'(delta.day_diff) * csd_pkg::PROD_W'(DAY_SCALE);

    always_comb
    begin
        sum = csd_pkg::SUM_W'(prod_reg) + csd_pkg::SUM_W'(tod_diff_reg);
        priority if (!earlier_reg || sum < 0)
            diff_next = '0;
        else if (sum > DIFF_MAX)
            diff_next = '1;
        else
            diff_next = sum[csd_pkg::DIFF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg     <= prod_next;
            tod_diff_reg <= delta.tod_diff;
            earlier_reg  <= delta.earlier;
            diff_reg     <= diff_next;
        end
    end

    assign diff_seconds = diff_reg;

endmodule

// ----- sv/calendar_seconds_difference.sv -----
// Seconds between two calendar timestamps with years 2000 to 2099.
// The input channel (in_valid, in_ready) carries one item: a start and an end
// timestamp as year offset, month, day, hour, minute and second fields.
// The output channel (out_valid, out_ready) returns one item per input item:
// diff_seconds, the seconds from start to end, or zero when the start is not
// earlier than the end.
// out_valid rises once an accepted item reaches the last of the four register
// stages; throughput is one item per cycle while the receiver does not stall.
// The four register stages are: day counts and order test, differences, the
// multiply by 86400, and the final add with clamping.
// The last stage is the output register.
// While the receiver stalls with an item pending, the whole pipeline holds
// and in_ready is low; no item is lost or repeated. Items in flight keep
// moving while in_ready is high, so a new item can enter as one leaves.
// Reset clears all stage valid bits; the pipeline is empty after reset and
// in_ready is high.
module calendar_seconds_difference (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [csd_pkg::YEAR_W-1:0]     from_year,
    input  logic [csd_pkg::MONTH_W-1:0]    from_month,
    input  logic [csd_pkg::DAY_W-1:0]      from_day,
    input  logic [csd_pkg::HOUR_W-1:0]     from_hour,
    input  logic [csd_pkg::MINUTE_W-1:0]   from_minute,
    input  logic [csd_pkg::SECOND_W-1:0]   from_second,
    input  logic [csd_pkg::YEAR_W-1:0]     to_year,
    input  logic [csd_pkg::MONTH_W-1:0]    to_month,
    input  logic [csd_pkg::DAY_W-1:0]      to_day,
    input  logic [csd_pkg::HOUR_W-1:0]     to_hour,
    input  logic [csd_pkg::MINUTE_W-1:0]   to_minute,
    input  logic [csd_pkg::SECOND_W-1:0]   to_second,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [csd_pkg::DIFF_W-1:0]     diff_seconds
);

    logic [csd_pkg::NUM_STAGES-1:0] valid_reg, valid_next;
    logic                           en;
    csd_pkg::csd_delta_t            delta;

    // The pipeline only halts when the output register holds an item not yet taken.
    assign en        = !(valid_reg[csd_pkg::NUM_STAGES-1] && !out_ready);
    assign in_ready  = en;
    assign out_valid = valid_reg[csd_pkg::NUM_STAGES-1];

    always_comb
    begin
        if (en)
            valid_next = {valid_reg[csd_pkg::NUM_STAGES-2:0], in_valid};
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    csd_front u_front (
        .clk         (clk),
        .en          (en),
        .from_year   (from_year),
        .from_month  (from_month),
        .from_day    (from_day),
        .from_hour   (from_hour),
        .from_minute (from_minute),
        .from_second (from_second),
        .to_year     (to_year),
        .to_month    (to_month),
        .to_day      (to_day),
        .to_hour     (to_hour),
        .to_minute   (to_minute),
        .to_second   (to_second),
        .delta       (delta)
    );

    csd_scale u_scale (
        .clk          (clk),
        .en           (en),
        .delta        (delta),
        .diff_seconds (diff_seconds)
    );

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(valid_reg))
        else $error("stage valid bits changed during a stall");

    a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !out_ready) |=>
            valid_reg[csd_pkg::NUM_STAGES-1:1] == $past(valid_reg[csd_pkg::NUM_STAGES-2:0]))
        else $error("stage valid bits did not advance");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted item did not enter the first stage");

    a_ready_low_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without a pending result");

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1750;
    localparam int IDLE_PERCENT   = 12;
    localparam int DRAIN_AT       = 600;
    localparam int LONG_STALL     = 60;
    localparam int STALL_AT       = 300;
    localparam int QUIET_FIRST    = 1000;
    localparam int QUIET_LAST     = 1250;
    localparam int END_CYCLES     = 20;
    localparam int PCT_NOISE      = 10;
    localparam int PCT_EQUAL      = 20;
    localparam int PCT_UNORDERED  = 30;

    localparam int DAYS_BEFORE_COMMON [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };
    localparam int DAYS_BEFORE_LEAP [12] = '{
        0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335
    };

    typedef struct packed {
        logic [csd_pkg::YEAR_W-1:0]   year;
        logic [csd_pkg::MONTH_W-1:0]  month;
        logic [csd_pkg::DAY_W-1:0]    day;
        logic [csd_pkg::HOUR_W-1:0]   hour;
        logic [csd_pkg::MINUTE_W-1:0] minute;
        logic [csd_pkg::SECOND_W-1:0] second;
    } stamp_t;

    typedef struct packed {
        stamp_t start;
        stamp_t stop;
    } span_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [csd_pkg::DIFF_W-1:0] diff_seconds;

    logic [csd_pkg::YEAR_W-1:0]   from_year = '0;
    logic [csd_pkg::MONTH_W-1:0]  from_month = '0;
    logic [csd_pkg::DAY_W-1:0]    from_day = '0;
    logic [csd_pkg::HOUR_W-1:0]   from_hour = '0;
    logic [csd_pkg::MINUTE_W-1:0] from_minute = '0;
    logic [csd_pkg::SECOND_W-1:0] from_second = '0;
    logic [csd_pkg::YEAR_W-1:0]   to_year = '0;
    logic [csd_pkg::MONTH_W-1:0]  to_month = '0;
    logic [csd_pkg::DAY_W-1:0]    to_day = '0;
    logic [csd_pkg::HOUR_W-1:0]   to_hour = '0;
    logic [csd_pkg::MINUTE_W-1:0] to_minute = '0;
    logic [csd_pkg::SECOND_W-1:0] to_second = '0;

    span_t                      pending_spans [$];
    logic [csd_pkg::DIFF_W-1:0] expected_diffs [$];
    span_t                      cur_span;
    int                         spans_sent = 0;
    int                         diffs_seen = 0;
    int                         error_count = 0;
    int                         stall_left = 0;
    bit                         stall_done = 1'b0;
    logic                       rx_holding = 1'b0;

    calendar_seconds_difference u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .from_year   (from_year),
        .from_month  (from_month),
        .from_day    (from_day),
        .from_hour   (from_hour),
        .from_minute (from_minute),
        .from_second (from_second),
        .to_year     (to_year),
        .to_month    (to_month),
        .to_day      (to_day),
        .to_hour     (to_hour),
        .to_minute   (to_minute),
        .to_second   (to_second),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .diff_seconds(diff_seconds)
    );

    always #5 clk = ~clk;

    // Days since the start of year offset zero; month codes outside 1..12 clamp.
    function automatic longint day_number(stamp_t s);
        longint yr;
        int     idx;
        int     prior_days;
        yr = s.year;
        if (s.month == '0)
            idx = 0;
        else if (s.month > 4'd12)
            idx = 11;
        else
            idx = int'(s.month) - 1;
        prior_days = (s.year[1:0] == 2'b00) ? DAYS_BEFORE_LEAP[idx] : DAYS_BEFORE_COMMON[idx];
        return yr * 365 + (yr + 3) / 4 + prior_days + longint'(s.day);
    endfunction

    function automatic longint seconds_of_day(stamp_t s);
        return longint'(s.hour) * 3600 + longint'(s.minute) * 60 + longint'(s.second);
    endfunction

    function automatic logic [csd_pkg::DIFF_W-1:0] seconds_between(span_t sp);
        longint delta;
        // The packed layout puts year first, so a plain compare is the raw field order.
        if (!(sp.start < sp.stop))
            return '0;
        delta = (day_number(sp.stop) - day_number(sp.start)) * 86400
              + seconds_of_day(sp.stop) - seconds_of_day(sp.start);
        if (delta < 0)
            return '0;
        if (delta > 64'hFFFF_FFFF)
            return '1;
        return csd_pkg::DIFF_W'(delta);
    endfunction

    function automatic stamp_t mk(int y, int mo, int d, int h, int mi, int s);
        stamp_t st;
        st.year   = csd_pkg::YEAR_W'(y);
        st.month  = csd_pkg::MONTH_W'(mo);
        st.day    = csd_pkg::DAY_W'(d);
        st.hour   = csd_pkg::HOUR_W'(h);
        st.minute = csd_pkg::MINUTE_W'(mi);
        st.second = csd_pkg::SECOND_W'(s);
        return st;
    endfunction

    // Redraws in-range values for every field from position first onward.
    function automatic stamp_t redraw(stamp_t s, int first);
        stamp_t st;
        st = s;
        if (first <= 0) st.year   = csd_pkg::YEAR_W'($urandom_range(0, 99));
        if (first <= 1) st.month  = csd_pkg::MONTH_W'($urandom_range(1, 12));
        if (first <= 2) st.day    = csd_pkg::DAY_W'($urandom_range(1, 31));
        if (first <= 3) st.hour   = csd_pkg::HOUR_W'($urandom_range(0, 23));
        if (first <= 4) st.minute = csd_pkg::MINUTE_W'($urandom_range(0, 59));
        if (first <= 5) st.second = csd_pkg::SECOND_W'($urandom_range(0, 59));
        return st;
    endfunction

    function automatic span_t random_span();
        span_t sp;
        stamp_t tmp;
        logic [95:0] noise;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < PCT_NOISE) begin
            noise = {$urandom, $urandom, $urandom};
            sp = span_t'(noise[$bits(span_t)-1:0]);
        end else begin
            sp.start = redraw('0, 0);
            if (pick < PCT_EQUAL)
                sp.stop = sp.start;
            else
                sp.stop = redraw(sp.start, $urandom_range(0, 5));
            // Most pairs run forward in time; the rest keep whatever order they drew.
            if (pick >= PCT_UNORDERED && sp.stop < sp.start) begin
                tmp = sp.start;
                sp.start = sp.stop;
                sp.stop = tmp;
            end
        end
        return sp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin : drive_blk
            logic offer;
            bit   idle;
            offer = in_valid;
            if (in_valid && in_ready) begin
                expected_diffs.push_back(seconds_between(cur_span));
                spans_sent++;
                offer = 1'b0;
            end
            idle = ($urandom_range(0, 99) < IDLE_PERCENT) && !rx_holding
                && !(spans_sent >= QUIET_FIRST && spans_sent < QUIET_LAST);
            // Once, the sender waits for the pipeline to empty completely.
            if (spans_sent == DRAIN_AT && expected_diffs.size() != 0)
                idle = 1'b1;
            if (!offer && pending_spans.size() != 0 && !idle) begin
                cur_span = pending_spans.pop_front();
                offer = 1'b1;
                from_year   <= cur_span.start.year;
                from_month  <= cur_span.start.month;
                from_day    <= cur_span.start.day;
                from_hour   <= cur_span.start.hour;
                from_minute <= cur_span.start.minute;
                from_second <= cur_span.start.second;
                to_year     <= cur_span.stop.year;
                to_month    <= cur_span.stop.month;
                to_day      <= cur_span.stop.day;
                to_hour     <= cur_span.stop.hour;
                to_minute   <= cur_span.stop.minute;
                to_second   <= cur_span.stop.second;
            end
            in_valid <= offer;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_holding <= 1'b0;
        end else begin : monitor_blk
            logic [csd_pkg::DIFF_W-1:0] want;
            logic ready_next;
            if (out_valid && out_ready) begin
                if (expected_diffs.size() == 0) begin
                    $display("%0t ERROR: unexpected item, expected none, got diff_seconds %0d",
                             $time, diff_seconds);
                    error_count++;
                end else begin
                    want = expected_diffs.pop_front();
                    if (diff_seconds !== want) begin
                        $display("%0t ERROR: diff_seconds expected %0d, got %0d",
                                 $time, want, diff_seconds);
                        error_count++;
                    end
                end
                diffs_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (diffs_seen >= STALL_AT && !stall_done) begin
                // Long hold-off so the pipeline backs up into in_ready.
                stall_done = 1'b1;
                stall_left = LONG_STALL;
                ready_next = 1'b0;
            end else begin
                ready_next = ($urandom_range(0, 99) >= IDLE_PERCENT)
                    || (diffs_seen >= QUIET_FIRST && diffs_seen < QUIET_LAST);
            end
            rx_holding <= (stall_left > 0);
            out_ready <= ready_next;
        end
    end

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        span_t sp;
        sp.start = mk(0, 1, 1, 0, 0, 0);    sp.stop = mk(99, 12, 31, 23, 59, 59);
        pending_spans.push_back(sp);
        sp.start = mk(37, 6, 15, 12, 30, 30); sp.stop = sp.start;
        pending_spans.push_back(sp);
        sp.start = mk(50, 7, 4, 8, 0, 0);   sp.stop = mk(49, 7, 4, 8, 0, 0);
        pending_spans.push_back(sp);
        sp.start = mk(21, 3, 9, 10, 20, 29); sp.stop = mk(21, 3, 9, 10, 20, 30);
        pending_spans.push_back(sp);
        // Leap start year with the start date after February.
        sp.start = mk(4, 3, 1, 0, 0, 0);    sp.stop = mk(5, 3, 1, 0, 0, 0);
        pending_spans.push_back(sp);
        sp.start = mk(3, 12, 31, 23, 59, 59); sp.stop = mk(4, 1, 1, 0, 0, 0);
        pending_spans.push_back(sp);
        sp.start = mk(4, 2, 28, 6, 0, 0);   sp.stop = mk(4, 3, 1, 6, 0, 0);
        pending_spans.push_back(sp);
        sp.start = mk(0, 2, 29, 0, 0, 0);   sp.stop = mk(0, 3, 1, 0, 0, 0);
        pending_spans.push_back(sp);
        // Month codes outside 1..12 clamp in the tables but not in the order test.
        sp.start = mk(10, 0, 5, 0, 0, 0);   sp.stop = mk(10, 1, 5, 0, 0, 0);
        pending_spans.push_back(sp);
        sp.start = mk(10, 12, 5, 0, 0, 0);  sp.stop = mk(10, 15, 5, 0, 0, 0);
        pending_spans.push_back(sp);
        sp.start = mk(10, 13, 1, 0, 0, 0);  sp.stop = mk(11, 0, 1, 0, 0, 0);
        pending_spans.push_back(sp);
        sp.start = mk(20, 5, 0, 0, 0, 0);   sp.stop = mk(20, 5, 1, 0, 0, 0);
        pending_spans.push_back(sp);
        sp.start = mk(20, 5, 1, 0, 0, 0);   sp.stop = mk(20, 5, 1, 31, 63, 63);
        pending_spans.push_back(sp);
        // Earlier by fields, yet the arithmetic goes negative.
        sp.start = mk(10, 1, 31, 23, 0, 0); sp.stop = mk(10, 2, 0, 0, 0, 0);
        pending_spans.push_back(sp);
        sp.start = mk(0, 0, 0, 0, 0, 0);    sp.stop = mk(127, 15, 31, 31, 63, 63);
        pending_spans.push_back(sp);
        sp.start = mk(127, 15, 31, 31, 63, 63); sp.stop = mk(0, 0, 0, 0, 0, 0);
        pending_spans.push_back(sp);
        sp.start = mk(66, 9, 9, 1, 59, 59); sp.stop = mk(66, 9, 9, 22, 0, 0);
        pending_spans.push_back(sp);
        sp.start = mk(126, 12, 31, 0, 0, 0); sp.stop = mk(127, 1, 1, 0, 0, 0);
        pending_spans.push_back(sp);
        sp.start = mk(99, 12, 31, 23, 59, 58); sp.stop = mk(99, 12, 31, 23, 59, 59);
        pending_spans.push_back(sp);
        sp.start = mk(0, 0, 0, 0, 0, 0);    sp.stop = mk(0, 0, 0, 0, 0, 1);
        pending_spans.push_back(sp);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_spans.push_back(random_span());

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_spans.size() != 0 || in_valid || expected_diffs.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- calendar_seconds_difference.f -----
sv/csd_pkg.sv
sv/csd_front.sv
sv/csd_scale.sv
sv/calendar_seconds_difference.sv
tb/sv/tb_top.sv
